FILE: sv/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants for the interpolation search table
// Request codes, status codes, controller states and parameter defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ist_pkg;

  // Parameter defaults
  localparam int IST_DEPTH      = 128;
  localparam int IST_WORD_WIDTH = 32;

  // Configuration register reset value
  localparam logic [7:0] THRESHOLD_RESET = 8'd5;

  // Request codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LIN,
    ST_RD_LO,
    ST_RD_HI,
    ST_START,
    ST_DIV,
    ST_PROBE,
    ST_DONE
  } ist_state_e;

endpackage

FILE: sv/ist_interp.sv
// ----------------------------------------------------------------------------
// ist_interp: interpolation offset unit
// Computes span * dk / den. The product loads on start_i, then one quotient
// bit per cycle. The caller guarantees dk <= den, so the quotient fits in
// IDX_W bits and never exceeds span.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ist_interp #(
  parameter int IDX_W      = 7,
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [IDX_W-1:0]      span_i,
  input  logic [WORD_WIDTH-1:0] dk_i,
  input  logic [WORD_WIDTH-1:0] den_i,
  output logic                  done_o,
  output logic [IDX_W-1:0]      quot_o
);

  localparam int NW    = IDX_W + WORD_WIDTH;
  localparam int CNT_W = $clog2(IDX_W + 1);

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [WORD_WIDTH-1:0] rem_q, rem_d;
  logic [IDX_W-1:0]      quo_q, quo_d;
  logic [NW-1:0]         prod;
  logic [WORD_WIDTH:0]   trial;
  logic                  ge;

  // Product of span and key offset
  assign prod = NW'(span_i) * NW'(dk_i);

  // One restoring division step
  assign trial = {rem_q, quo_q[IDX_W-1]};
  assign ge    = trial >= {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(IDX_W);
      rem_d  = prod[NW-1:IDX_W];
      quo_d  = prod[IDX_W-1:0];
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
        rem_d = ge ? WORD_WIDTH'(trial - {1'b0, den_i}) : trial[WORD_WIDTH-1:0];
        quo_d = IDX_W'({quo_q, ge});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quo_q;

endmodule

FILE: sv/interpolation_search_table.sv
// ----------------------------------------------------------------------------
// interpolation_search_table: sorted word store with interpolation search
// Appends words, clears the store, and searches a clipped index range by
// linear scan or interpolation probing.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  in        slave      in_valid_i/in_ready_o  op, data_word, left/right index
//  out       master     out_valid_o/out_ready_i found, position, used_count, status
//  cfg       slave      cfg_we_i               cfg_wdata_i (linear threshold)
//
// One request at a time. Append, clear and unused codes go from the idle state
// through the done state to the output register. A search range at or under
// the threshold scans one entry per cycle off the single memory read port.
// Each interpolation probe reads the left end, then the right end, runs the
// bit-serial divider unless the end values are equal, and reads the probe.
// Reset clears the entry count, state and output valid and restores the threshold; the store needs no clearing pass.
// A result waiting on out_ready_i holds the controller in its done state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interpolation_search_table
  import ist_pkg::*;
#(
  parameter int DEPTH      = IST_DEPTH,
  parameter int WORD_WIDTH = IST_WORD_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [7:0]                   cfg_wdata_i,
  // request
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic signed [WORD_WIDTH-1:0] data_word_i,
  input  logic [$clog2(DEPTH)-1:0]     left_index_i,
  input  logic [$clog2(DEPTH)-1:0]     right_index_i,
  // result
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [$clog2(DEPTH)-1:0]     position_o,
  output logic [$clog2(DEPTH+1)-1:0]   used_count_o,
  output logic [1:0]                   status_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

  ist_state_e state_q, state_d;

  logic [7:0]                   thr_q;
  logic [CW-1:0]                used_q, used_d;
  logic signed [WORD_WIDTH-1:0] key_q, key_d;
  logic signed [WORD_WIDTH-1:0] vl_q, vl_d;
  logic [WORD_WIDTH-1:0]        dk_q, dk_d;
  logic [WORD_WIDTH-1:0]        den_q, den_d;
  logic [CW-1:0]                lo_q, lo_d;
  logic [CW-1:0]                hi_q, hi_d;
  logic [CW-1:0]                scan_q, scan_d;
  logic [CW-1:0]                pos_q, pos_d;
  logic                         res_found_q, res_found_d;
  logic [IDX_W-1:0]             res_pos_q, res_pos_d;
  logic [1:0]                   res_status_q, res_status_d;

  logic                         out_valid_q;
  logic                         out_found_q;
  logic [IDX_W-1:0]             out_pos_q;
  logic [CW-1:0]                out_used_q;
  logic [1:0]                   out_status_q;

  // Element store
  logic signed [WORD_WIDTH-1:0] mem [DEPTH];
  logic signed [WORD_WIDTH-1:0] rdata_q;
  logic [IDX_W-1:0]             rd_addr;
  logic                         mem_we;

  // Divider interface
  logic                         div_start;
  logic                         div_done;
  logic [IDX_W-1:0]             div_quot;
  logic [CW-1:0]                div_pos;

  // Shared conditions
  logic          in_fire, out_free, full;
  logic [CW-1:0] last_idx, right_ext, right_clip, size;
  logic          range_ok, chk_empty, chk_linear;
  logic          lin_hit, lin_end;
  logic          key_out, ends_eq;
  logic          prb_hit, prb_less, pos_zero;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign full       = (used_q == DEPTH_CW);

  assign last_idx   = used_q - CW'(1);
  assign right_ext  = CW'(right_index_i);
  assign right_clip = (right_ext > last_idx) ? last_idx : right_ext;
  assign range_ok   = (used_q != '0) && (CW'(left_index_i) <= right_clip);

  assign chk_empty  = lo_q > hi_q;
  assign size       = hi_q - lo_q + CW'(1);
  assign chk_linear = CMP_W'(size) <= CMP_W'(thr_q);

  assign lin_hit    = (rdata_q == key_q);
  assign lin_end    = (scan_q == hi_q);

  // rdata_q holds the right end value in ST_RD_HI
  assign key_out    = (key_q < vl_q) || (key_q > rdata_q);
  assign ends_eq    = (rdata_q == vl_q);

  assign prb_hit    = (rdata_q == key_q);
  assign prb_less   = (rdata_q < key_q);
  assign pos_zero   = (pos_q == '0);

  assign div_pos    = lo_q + CW'(div_quot);
  assign div_start  = (state_q == ST_START);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (op_i == OP_SEARCH && range_ok) ? ST_CHECK : ST_DONE;
        end
      end
      ST_CHECK: begin
        if (chk_empty)       state_d = ST_DONE;
        else if (chk_linear) state_d = ST_LIN;
        else                 state_d = ST_RD_LO;
      end
      ST_LIN: begin
        if (lin_hit || lin_end) state_d = ST_DONE;
      end
      ST_RD_LO: state_d = ST_RD_HI;
      ST_RD_HI: begin
        if (key_out)      state_d = ST_DONE;
        else if (ends_eq) state_d = ST_PROBE;
        else              state_d = ST_START;
      end
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (prb_hit)       state_d = ST_DONE;
        else if (prb_less) state_d = ST_CHECK;
        else if (pos_zero) state_d = ST_DONE;
        else               state_d = ST_CHECK;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    used_d       = used_q;
    key_d        = key_q;
    vl_d         = vl_q;
    dk_d         = dk_q;
    den_d        = den_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    scan_d       = scan_q;
    pos_d        = pos_q;
    res_found_d  = res_found_q;
    res_pos_d    = res_pos_q;
    res_status_d = res_status_q;
    rd_addr      = lo_q[IDX_W-1:0];
    mem_we       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          key_d        = data_word_i;
          lo_d         = CW'(left_index_i);
          hi_d         = right_clip;
          res_found_d  = 1'b0;
          res_pos_d    = '0;
          res_status_d = STATUS_OK;
          case (op_i)
            OP_APPEND: begin
              if (full) begin
                res_status_d = STATUS_FULL;
              end else begin
                mem_we = 1'b1;
                used_d = used_q + CW'(1);
              end
            end
            OP_SEARCH: begin
              if (!range_ok) res_status_d = STATUS_EMPTY;
            end
            OP_CLEAR: used_d = '0;
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        scan_d = lo_q;
      end
      ST_LIN: begin
        if (lin_hit) begin
          res_found_d = 1'b1;
          res_pos_d   = scan_q[IDX_W-1:0];
        end else begin
          scan_d  = scan_q + CW'(1);
          rd_addr = scan_d[IDX_W-1:0];
        end
      end
      ST_RD_LO: begin
        vl_d    = rdata_q;
        rd_addr = hi_q[IDX_W-1:0];
      end
      ST_RD_HI: begin
        dk_d  = key_q - vl_q;
        den_d = rdata_q - vl_q;
        pos_d = lo_q;
      end
      ST_START: ;
      ST_DIV: begin
        pos_d   = div_pos;
        rd_addr = div_pos[IDX_W-1:0];
      end
      ST_PROBE: begin
        if (prb_hit) begin
          res_found_d = 1'b1;
          res_pos_d   = pos_q[IDX_W-1:0];
        end else if (prb_less) begin
          lo_d = pos_q + CW'(1);
        end else if (!pos_zero) begin
          hi_d = pos_q - CW'(1);
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[used_q[IDX_W-1:0]] <= data_word_i;
    rdata_q <= mem[rd_addr];
  end

  // Interpolation offset unit
  ist_interp #(
    .IDX_W      (IDX_W),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .span_i  (IDX_W'(hi_q - lo_q)),
    .dk_i    (dk_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      thr_q       <= THRESHOLD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    vl_q         <= vl_d;
    dk_q         <= dk_d;
    den_q        <= den_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    scan_q       <= scan_d;
    pos_q        <= pos_d;
    res_found_q  <= res_found_d;
    res_pos_q    <= res_pos_d;
    res_status_q <= res_status_d;
    if (state_q == ST_DONE && out_free) begin
      out_found_q  <= res_found_q;
      out_pos_q    <= res_pos_q;
      out_used_q   <= used_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_found_q;
  assign position_o   = out_pos_q;
  assign used_count_o = out_used_q;
  assign status_o     = out_status_q;

  // Checks
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request accepted while another is in progress");

  a_hit_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (CW'(position_o) < used_count_o))
    else $error("hit position beyond used entries");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_FULL) |-> (used_count_o == DEPTH_CW))
    else $error("full status with room in store");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (pos_q >= lo_q && pos_q <= hi_q))
    else $error("probe index outside search range");

endmodule

FILE: verif/interpolation_search_table_tb.sv
// ----------------------------------------------------------------------------
// interpolation_search_table_tb: self-checking bench for the search table
// Drives append, clear, search and unused-code requests with random idling on both
// channels, predicts every result from a behavioral copy of the table and
// compares each field. The linear-scan threshold is swept between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interpolation_search_table_tb;
  import ist_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         STALL_LIMIT  = 20000;
  localparam int         PHASE_ITEMS  = 130;

  typedef struct {
    logic       found;
    logic [6:0] position;
    logic [7:0] used_count;
    logic [1:0] status;
  } lookup_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [7:0]         cfg_wdata_i   = 8'd0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [1:0]         op_i          = OP_APPEND;
  logic signed [31:0] data_word_i   = '0;
  logic [6:0]         left_index_i  = '0;
  logic [6:0]         right_index_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic               found_o;
  logic [6:0]         position_o;
  logic [7:0]         used_count_o;
  logic [1:0]         status_o;

  // Behavioral copy of the table and its threshold
  logic signed [31:0] table_words [IST_DEPTH];
  int                 table_fill;
  logic [7:0]         scan_threshold;

  lookup_result_t     pending_results[$];
  int                 error_count    = 0;
  int                 requests_sent  = 0;
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  int                 quiet_cycles   = 0;

  interpolation_search_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .data_word_i   (data_word_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .position_o    (position_o),
    .used_count_o  (used_count_o),
    .status_o      (status_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Interpolation search over [lo, hi] of the predicted table
  function automatic bit locate_key(input logic signed [31:0] key, input int lo_in,
                                    input int hi_in, output int hit);
    int     lo, hi, pos, i;
    longint key_l, v_lo, v_hi, num, den, off;
    lo    = lo_in;
    hi    = hi_in;
    hit   = 0;
    key_l = key;
    while (lo <= hi) begin
      // small range: first match from the left
      if (hi - lo + 1 <= int'(scan_threshold)) begin
        for (i = lo; i <= hi; i++) begin
          if (table_words[i] == key) begin
            hit = i;
            return 1'b1;
          end
        end
        return 1'b0;
      end
      v_lo = table_words[lo];
      v_hi = table_words[hi];
      if (key_l < v_lo || key_l > v_hi) return 1'b0;
      if (v_lo == v_hi) begin
        pos = lo;
      end else begin
        num = longint'(hi - lo) * (key_l - v_lo);
        den = v_hi - v_lo;
        off = num / den;
        pos = (off > longint'(hi - lo)) ? hi : lo + int'(off);
      end
      if (table_words[pos] == key) begin
        hit = pos;
        return 1'b1;
      end
      if (table_words[pos] < key) begin
        lo = pos + 1;
      end else begin
        if (pos == 0) return 1'b0;
        hi = pos - 1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one request to the predicted table and returns its result
  function automatic lookup_result_t predict_result(input logic [1:0] op,
                                                    input logic signed [31:0] word,
                                                    input logic [6:0] left,
                                                    input logic [6:0] right);
    lookup_result_t r;
    int             lo, hi, hit;
    r.found    = 1'b0;
    r.position = '0;
    r.status   = STATUS_OK;
    case (op)
      OP_APPEND: begin
        if (table_fill < IST_DEPTH) begin
          table_words[table_fill] = word;
          table_fill++;
        end else begin
          r.status = STATUS_FULL;
        end
      end
      OP_CLEAR: begin
        table_fill = 0;
      end
      OP_SEARCH: begin
        if (table_fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          lo = int'(left);
          hi = (int'(right) > table_fill - 1) ? table_fill - 1 : int'(right);
          if (lo > hi) begin
            r.status = STATUS_EMPTY;
          end else if (locate_key(word, lo, hi, hit)) begin
            r.found    = 1'b1;
            r.position = 7'(hit);
          end
        end
      end
      default: ;
    endcase
    r.used_count = 8'(table_fill);
    return r;
  endfunction

  // Sends one request; valid stays high afterwards unless a gap follows
  task automatic send_request(input logic [1:0] op, input logic signed [31:0] word,
                              input logic [6:0] left, input logic [6:0] right);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    data_word_i   <= word;
    left_index_i  <= left;
    right_index_i <= right;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(predict_result(op, word, left, right));
    requests_sent++;
  endtask

  // Holds off new requests until every result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    scan_threshold  = value;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Clear, append an ascending run of words, then search it
  task automatic run_sorted_burst(input int n_words, input int n_searches);
    int                 words[$];
    int                 spread, i;
    logic signed [31:0] key;
    logic [6:0]         left, right;
    spread = $urandom_range(2);
    for (i = 0; i < n_words; i++) begin
      case (spread)
        0:       words.push_back(int'($urandom));
        1:       words.push_back(int'($urandom_range(40)) - 20);
        default: words.push_back(int'($urandom_range(100000)) * 1000);
      endcase
    end
    words.sort();
    send_request(OP_CLEAR, $urandom, 7'($urandom), 7'($urandom));
    foreach (words[j]) send_request(OP_APPEND, words[j], 7'($urandom), 7'($urandom));
    for (i = 0; i < n_searches; i++) begin
      case ($urandom_range(3))
        0, 1: key = table_words[$urandom_range(table_fill - 1)];
        2:    key = table_words[$urandom_range(table_fill - 1)] + 1;
        default: key = $urandom;
      endcase
      left  = $urandom_range(1) ? 7'd0 : 7'($urandom_range(table_fill - 1));
      right = $urandom_range(1) ? 7'd127 : 7'($urandom_range(127));
      send_request(OP_SEARCH, key, left, right);
    end
  endtask

  // Search and unused code on an empty table, then a clear
  task automatic test_empty_table();
    send_request(OP_SEARCH, 32'sd7, 7'd0, 7'd127);
    send_request(OP_UNUSED, 32'sd7, 7'd0, 7'd127);
    send_request(OP_CLEAR, 32'sd0, 7'd0, 7'd0);
  endtask

  // Word extremes, clipped and inverted ranges, keys outside the probed ends
  task automatic test_extreme_words();
    send_request(OP_APPEND, 32'sh8000_0000, 7'd0, 7'd0);
    send_request(OP_APPEND, -32'sd1000, 7'd0, 7'd0);
    send_request(OP_APPEND, -32'sd1, 7'd0, 7'd0);
    send_request(OP_APPEND, 32'sd0, 7'd0, 7'd0);
    send_request(OP_APPEND, 32'sd1, 7'd0, 7'd0);
    send_request(OP_APPEND, 32'sd1000, 7'd0, 7'd0);
    send_request(OP_APPEND, 32'sh7fff_ffff, 7'd0, 7'd0);
    send_request(OP_SEARCH, 32'sh8000_0000, 7'd0, 7'd127);
    send_request(OP_SEARCH, 32'sh7fff_ffff, 7'd0, 7'd127);
    send_request(OP_SEARCH, 32'sd0, 7'd0, 7'd127);
    send_request(OP_SEARCH, 32'sd2, 7'd0, 7'd127);
    send_request(OP_SEARCH, 32'sd1000, 7'd4, 7'd5);
    send_request(OP_SEARCH, -32'sd1001, 7'd1, 7'd6);
    send_request(OP_SEARCH, 32'sd1001, 7'd0, 7'd5);
    send_request(OP_SEARCH, 32'sd0, 7'd5, 7'd2);
    send_request(OP_SEARCH, 32'sd0, 7'd127, 7'd127);
    send_request(OP_UNUSED, 32'sd0, 7'd0, 7'd127);
  endtask

  // Equal end values: the probe lands on the left end
  task automatic test_equal_ends();
    int i;
    send_request(OP_CLEAR, 32'sd0, 7'd0, 7'd0);
    for (i = 0; i < 6; i++) send_request(OP_APPEND, 32'sd42, 7'd0, 7'd0);
    send_request(OP_SEARCH, 32'sd42, 7'd0, 7'd127);
    send_request(OP_SEARCH, 32'sd41, 7'd0, 7'd127);
  endtask

  // Fill every entry, then appends to a full table are dropped
  task automatic test_full_table();
    run_sorted_burst(IST_DEPTH, 16);
    send_request(OP_APPEND, $urandom, 7'd0, 7'd0);
    send_request(OP_APPEND, $urandom, 7'd0, 7'd0);
    send_request(OP_SEARCH, table_words[IST_DEPTH-1], 7'd0, 7'd127);
  endtask

  // Threshold extremes: always probe, always scan, and values between
  task automatic test_threshold_sweep();
    write_threshold(8'd0);
    run_sorted_burst($urandom_range(60, 128), 20);
    write_threshold(8'd128);
    run_sorted_burst($urandom_range(60, 128), 20);
    write_threshold(8'd1);
    run_sorted_burst($urandom_range(2, 30), 12);
    write_threshold(8'($urandom_range(2, 127)));
    run_sorted_burst($urandom_range(2, 40), 12);
  endtask

  // Mostly ascending bursts, some noise, under each idling pattern
  task automatic test_random_traffic();
    int send_pcts[4] = '{0, 53, 0, 7};
    int recv_pcts[4] = '{0, 0, 53, 7};
    int phase, phase_start;
    for (phase = 0; phase < 4; phase++) begin
      write_threshold(8'($urandom_range(0, 128)));
      set_idling(send_pcts[phase], recv_pcts[phase]);
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) begin
          if ($urandom_range(9) == 0) run_sorted_burst($urandom_range(100, 128), 10);
          else run_sorted_burst($urandom_range(1, 24), $urandom_range(4, 12));
        end else begin
          // noise: any code, unsorted words, arbitrary ranges
          repeat ($urandom_range(1, 8))
            send_request(2'($urandom_range(3)), $urandom, 7'($urandom), 7'($urandom));
        end
        // pause near the middle of each phase until the pipe is empty
        if (requests_sent - phase_start >= PHASE_ITEMS / 2 &&
            requests_sent - phase_start < PHASE_ITEMS / 2 + 30)
          wait_drained();
      end
    end
    set_idling(0, 0);
  endtask

  // Result check and receiver stalls
  always @(posedge clk_i) begin : result_check
    lookup_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          error_count++;
        end
        if (position_o !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, position_o);
          error_count++;
        end
        if (used_count_o !== want.used_count) begin
          $error("used_count: expected %0d, got %0d", want.used_count, used_count_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    table_fill     = 0;
    scan_threshold = THRESHOLD_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_extreme_words();
    test_equal_ends();
    test_full_table();
    test_threshold_sweep();
    test_random_traffic();

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
